// ===== design/pcsp_pkg.sv =====
`default_nettype none

package pcsp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PenW    = 11;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned AccW    = 24;
  localparam int unsigned ActW    = 3;
  localparam int unsigned FaultW  = 2;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned RegIdxW = 3;

  // result kinds
  localparam logic [ActW-1:0] ACT_START  = 3'd0;
  localparam logic [ActW-1:0] ACT_PEN    = 3'd1;
  localparam logic [ActW-1:0] ACT_MOVE   = 3'd2;
  localparam logic [ActW-1:0] ACT_DRAW   = 3'd3;
  localparam logic [ActW-1:0] ACT_FINISH = 3'd4;
  localparam logic [ActW-1:0] ACT_FAULT  = 3'd5;

  // fault reasons
  localparam logic [FaultW-1:0] FLT_NONE      = 2'd0;
  localparam logic [FaultW-1:0] FLT_EOF_FIELD = 2'd0;
  localparam logic [FaultW-1:0] FLT_BAD_CODE  = 2'd1;
  localparam logic [FaultW-1:0] FLT_EOF_CMD   = 2'd2;
  localparam logic [FaultW-1:0] FLT_NO_BEGIN  = 2'd3;

  // register map, index = byte address / 4
  localparam logic [RegIdxW-1:0] REG_PEN_COUNT    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_CODE_BEGIN   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_CODE_END     = 3'd2;
  localparam logic [RegIdxW-1:0] REG_CODE_PEN_S   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_CODE_PEN_L   = 3'd4;
  localparam logic [RegIdxW-1:0] REG_CODE_DRAW    = 3'd5;
  localparam logic [RegIdxW-1:0] REG_CODE_MOVE    = 3'd6;
  localparam logic [RegIdxW-1:0] REG_CODE_SPECIAL = 3'd7;

  typedef struct packed {
    logic [PenW-1:0]  pen_count;
    logic [ByteW-1:0] code_begin;
    logic [ByteW-1:0] code_end;
    logic [ByteW-1:0] code_pen_short;
    logic [ByteW-1:0] code_pen_long;
    logic [ByteW-1:0] code_draw;
    logic [ByteW-1:0] code_move;
    logic [ByteW-1:0] code_special;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pen_count:      11'd1,
    code_begin:     8'd1,
    code_end:       8'd2,
    code_pen_short: 8'd3,
    code_pen_long:  8'd4,
    code_draw:      8'd5,
    code_move:      8'd6,
    code_special:   8'd7
  };

  // controller to datapath
  typedef struct packed {
    logic              pen_load;
    logic              pen_shift;
    logic              hi_load;
    logic              x_load;
    logic              div_start;
    logic              out_load;
    logic [ActW-1:0]   out_action;
    logic [FaultW-1:0] out_fault;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/pcsp_cfg.sv =====
`default_nettype none

module pcsp_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pcsp_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output pcsp_pkg::cfg_t                  cfg_o
);
  import pcsp_pkg::*;

  cfg_t                cfg_q, cfg_d;
  logic [RegIdxW-1:0]  idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PEN_COUNT:    cfg_d.pen_count      = pwdata[PenW-1:0];
        REG_CODE_BEGIN:   cfg_d.code_begin     = pwdata[ByteW-1:0];
        REG_CODE_END:     cfg_d.code_end       = pwdata[ByteW-1:0];
        REG_CODE_PEN_S:   cfg_d.code_pen_short = pwdata[ByteW-1:0];
        REG_CODE_PEN_L:   cfg_d.code_pen_long  = pwdata[ByteW-1:0];
        REG_CODE_DRAW:    cfg_d.code_draw      = pwdata[ByteW-1:0];
        REG_CODE_MOVE:    cfg_d.code_move      = pwdata[ByteW-1:0];
        REG_CODE_SPECIAL: cfg_d.code_special   = pwdata[ByteW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PEN_COUNT:    prdata = {21'd0, cfg_q.pen_count};
      REG_CODE_BEGIN:   prdata = {24'd0, cfg_q.code_begin};
      REG_CODE_END:     prdata = {24'd0, cfg_q.code_end};
      REG_CODE_PEN_S:   prdata = {24'd0, cfg_q.code_pen_short};
      REG_CODE_PEN_L:   prdata = {24'd0, cfg_q.code_pen_long};
      REG_CODE_DRAW:    prdata = {24'd0, cfg_q.code_draw};
      REG_CODE_MOVE:    prdata = {24'd0, cfg_q.code_move};
      REG_CODE_SPECIAL: prdata = {24'd0, cfg_q.code_special};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/pcsp_dp.sv =====
`default_nettype none

module pcsp_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pcsp_pkg::cfg_t              cfg_i,
  input  wire logic [pcsp_pkg::ByteW-1:0]  byte_i,
  input  wire pcsp_pkg::cmd_t              cmd_i,
  output pcsp_pkg::sts_t                   sts_o,
  output logic [pcsp_pkg::ActW-1:0]        action_o,
  output logic [pcsp_pkg::PenW-1:0]        pen_number_o,
  output logic [pcsp_pkg::CoordW-1:0]      coord_x_o,
  output logic [pcsp_pkg::CoordW-1:0]      coord_y_o,
  output logic [pcsp_pkg::FaultW-1:0]      fault_code_o
);
  import pcsp_pkg::*;

  localparam int unsigned CntW = $clog2(AccW + 1);
  localparam logic [CntW-1:0] DivSteps = CntW'(AccW);

  logic [AccW-1:0]   acc_q, acc_d;
  logic [ByteW-1:0]  hi_q;
  logic [CoordW-1:0] x_q;

  // bit-serial restoring remainder
  logic [AccW-1:0]   dvd_q;
  logic [PenW-1:0]   rem_q;
  logic [PenW-1:0]   den_q;
  logic [CntW-1:0]   cnt_q;
  logic [PenW:0]     trial;
  logic              take;

  logic [ActW-1:0]   act_q;
  logic [PenW-1:0]   pen_q;
  logic [CoordW-1:0] ox_q, oy_q;
  logic [FaultW-1:0] flt_q;
  logic              is_xy;

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.pen_load) begin
      acc_d = {{(AccW-ByteW){1'b0}}, byte_i};
    end else if (cmd_i.pen_shift) begin
      acc_d = {acc_q[AccW-ByteW-1:0], byte_i};
    end
  end

  assign trial = {rem_q, dvd_q[AccW-1]};
  assign take  = trial >= {1'b0, den_q};
  assign sts_o.div_busy = (cnt_q != '0);

  assign is_xy = (cmd_i.out_action == ACT_MOVE) || (cmd_i.out_action == ACT_DRAW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= DivSteps;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.hi_load) begin
      hi_q <= byte_i;
    end
    if (cmd_i.x_load) begin
      x_q <= {hi_q, byte_i};
    end
    if (cmd_i.div_start) begin
      dvd_q <= acc_d;
      rem_q <= '0;
      den_q <= (cfg_i.pen_count == '0) ? PenW'(1) : cfg_i.pen_count;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[AccW-2:0], 1'b0};
      rem_q <= take ? PenW'(trial - {1'b0, den_q}) : trial[PenW-1:0];
    end
    if (cmd_i.out_load) begin
      act_q <= cmd_i.out_action;
      flt_q <= cmd_i.out_fault;
      pen_q <= (cmd_i.out_action == ACT_PEN) ? rem_q + 1'b1 : '0;
      ox_q  <= is_xy ? x_q : '0;
      oy_q  <= is_xy ? {hi_q, byte_i} : '0;
    end
  end

  assign action_o     = act_q;
  assign pen_number_o = pen_q;
  assign coord_x_o    = ox_q;
  assign coord_y_o    = oy_q;
  assign fault_code_o = flt_q;

endmodule

`default_nettype wire

// ===== design/pcsp_ctrl.sv =====
`default_nettype none

module pcsp_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire pcsp_pkg::cfg_t             cfg_i,
  input  wire logic                       in_valid_i,
  input  wire logic [pcsp_pkg::ByteW-1:0] byte_i,
  input  wire logic                       eos_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output pcsp_pkg::cmd_t                  cmd_o,
  input  wire pcsp_pkg::sts_t             sts_i
);
  import pcsp_pkg::*;

  localparam logic [3:0] PH_BEGIN   = 4'd0;
  localparam logic [3:0] PH_CMD     = 4'd1;
  localparam logic [3:0] PH_PEN0    = 4'd2;
  localparam logic [3:0] PH_PENL0   = 4'd3;
  localparam logic [3:0] PH_PENL1   = 4'd4;
  localparam logic [3:0] PH_PENL2   = 4'd5;
  localparam logic [3:0] PH_XH      = 4'd6;
  localparam logic [3:0] PH_XL      = 4'd7;
  localparam logic [3:0] PH_YH      = 4'd8;
  localparam logic [3:0] PH_YL      = 4'd9;
  localparam logic [3:0] PH_SPECIAL = 4'd10;
  localparam logic [3:0] PH_DIV     = 4'd11;
  localparam logic [3:0] PH_HALT    = 4'd12;

  logic [3:0] phase_q, phase_d;
  logic       draw_q, draw_d;
  logic       ovld_q, ovld_d;
  logic       slot_free;
  logic       fire;

  assign slot_free   = ~ovld_q | out_ready_i;
  assign in_ready_o  = (phase_q != PH_DIV) & slot_free;
  assign fire        = in_valid_i & in_ready_o;
  assign out_valid_o = ovld_q;

  always_comb begin
    phase_d = phase_q;
    draw_d  = draw_q;
    ovld_d  = ovld_q & ~out_ready_i;
    cmd_o   = '0;

    if (phase_q == PH_DIV) begin
      if (!sts_i.div_busy && slot_free) begin
        cmd_o.out_load   = 1'b1;
        cmd_o.out_action = ACT_PEN;
        ovld_d           = 1'b1;
        phase_d          = PH_CMD;
      end
    end else if (fire) begin
      priority if (phase_q == PH_HALT) begin
        phase_d = PH_HALT;
      end else if (phase_q == PH_BEGIN) begin
        cmd_o.out_load = 1'b1;
        ovld_d         = 1'b1;
        if (eos_i || byte_i != cfg_i.code_begin) begin
          cmd_o.out_action = ACT_FAULT;
          cmd_o.out_fault  = FLT_NO_BEGIN;
          phase_d          = PH_HALT;
        end else begin
          cmd_o.out_action = ACT_START;
          phase_d          = PH_CMD;
        end
      end else if (phase_q == PH_CMD) begin
        // equal codes resolve in this order
        priority if (eos_i) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_action = ACT_FAULT;
          cmd_o.out_fault  = FLT_EOF_CMD;
          ovld_d           = 1'b1;
          phase_d          = PH_HALT;
        end else if (byte_i == cfg_i.code_end) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_action = ACT_FINISH;
          ovld_d           = 1'b1;
          phase_d          = PH_HALT;
        end else if (byte_i == cfg_i.code_pen_long) begin
          phase_d = PH_PENL0;
        end else if (byte_i == cfg_i.code_pen_short) begin
          phase_d = PH_PEN0;
        end else if (byte_i == cfg_i.code_draw) begin
          draw_d  = 1'b1;
          phase_d = PH_XH;
        end else if (byte_i == cfg_i.code_move) begin
          draw_d  = 1'b0;
          phase_d = PH_XH;
        end else if (byte_i == cfg_i.code_special) begin
          phase_d = PH_SPECIAL;
        end else begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_action = ACT_FAULT;
          cmd_o.out_fault  = FLT_BAD_CODE;
          ovld_d           = 1'b1;
          phase_d          = PH_HALT;
        end
      end else if (eos_i) begin
        cmd_o.out_load   = 1'b1;
        cmd_o.out_action = ACT_FAULT;
        cmd_o.out_fault  = FLT_EOF_FIELD;
        ovld_d           = 1'b1;
        phase_d          = PH_HALT;
      end else begin
        unique case (phase_q)
          PH_PEN0: begin
            cmd_o.pen_load  = 1'b1;
            cmd_o.div_start = 1'b1;
            phase_d         = PH_DIV;
          end
          PH_PENL0: begin
            cmd_o.pen_load = 1'b1;
            phase_d        = PH_PENL1;
          end
          PH_PENL1: begin
            cmd_o.pen_shift = 1'b1;
            phase_d         = PH_PENL2;
          end
          PH_PENL2: begin
            cmd_o.pen_shift = 1'b1;
            cmd_o.div_start = 1'b1;
            phase_d         = PH_DIV;
          end
          PH_XH: begin
            cmd_o.hi_load = 1'b1;
            phase_d       = PH_XL;
          end
          PH_XL: begin
            cmd_o.x_load = 1'b1;
            phase_d      = PH_YH;
          end
          PH_YH: begin
            cmd_o.hi_load = 1'b1;
            phase_d       = PH_YL;
          end
          PH_YL: begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_action = draw_q ? ACT_DRAW : ACT_MOVE;
            ovld_d           = 1'b1;
            phase_d          = PH_CMD;
          end
          PH_SPECIAL: begin
            if (byte_i == '0) begin
              phase_d = PH_CMD;
            end
          end
          default: begin
            phase_d = PH_CMD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BEGIN;
      draw_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      draw_q  <= draw_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/plot_command_stream_parser_top.sv =====
`default_nettype none

// Plot command stream parser. Takes one stream byte per beat (tuser high marks
// end of stream) and emits start, pen select, move, draw, finish or fault
// results. The last byte of a pen command starts a bit-serial remainder unit
// that works one dividend bit per cycle; input is held off until the pen
// result is loaded into the output register. A result sits in an output
// register; the next beat is accepted while that register is empty or being
// drained in the same cycle. After a finish or a fault, beats are accepted
// and dropped until reset. Registers are written over the APB port at byte
// address 4*index; pen_count of zero acts as one.
module plot_command_stream_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] stream_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [10:0] pen_number, [26:11] coord_x, [42:27] coord_y, [44:43] fault_code
  output logic [47:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser,   // [2:0] action
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import pcsp_pkg::*;

  cfg_t              cfg;
  cmd_t              cmd;
  sts_t              sts;
  logic [PenW-1:0]   pen_number;
  logic [CoordW-1:0] coord_x, coord_y;
  logic [FaultW-1:0] fault_code;

  pcsp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .byte_i      (s_axis_tdata),
    .eos_i       (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pcsp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .byte_i       (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .action_o     (m_axis_tuser),
    .pen_number_o (pen_number),
    .coord_x_o    (coord_x),
    .coord_y_o    (coord_y),
    .fault_code_o (fault_code)
  );

  assign m_axis_tdata = {3'b000, fault_code, coord_y, coord_x, pen_number};

endmodule

`default_nettype wire

// ===== tb/plot_command_stream_parser_top_tb.sv =====
module plot_command_stream_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcsp_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1350;
  localparam int unsigned PHASE_BEATS   = 150;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned STALL_LIMIT   = 2000;

  typedef enum logic [3:0] {
    AWAIT_BEGIN, AWAIT_CMD, PEN_BYTE, LPEN_HI, LPEN_MID, LPEN_LO,
    X_HI, X_LO, Y_HI, Y_LO, SKIP_SPECIAL
  } parse_state_e;

  // listed in the order the block matches codes, end-of-plot comes first
  typedef enum int unsigned {
    CMD_PEN_LONG, CMD_PEN_SHORT, CMD_DRAW, CMD_MOVE, CMD_SPECIAL
  } cmd_kind_e;

  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [PenW-1:0]   pen;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [FaultW-1:0] fault;
  } plot_action_t;

  class plot_stream_tracker;
    cfg_t              cfg;
    parse_state_e      pstate;
    logic [AccW-1:0]   pen_acc;
    logic [CoordW-1:0] x_hold;
    logic [ByteW-1:0]  hi_hold;
    bit                draw_cmd;
    bit                halted;
    plot_action_t      owed_actions[$];
    int unsigned       mismatches;

    function new();
      cfg        = CFG_RESET;
      pstate     = AWAIT_BEGIN;
      pen_acc    = '0;
      x_hold     = '0;
      hi_hold    = '0;
      draw_cmd   = 1'b0;
      halted     = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return owed_actions.size();
    endfunction

    function void write_reg(input logic [RegIdxW-1:0] idx, input logic [31:0] value);
      case (idx)
        REG_PEN_COUNT:    cfg.pen_count      = value[PenW-1:0];
        REG_CODE_BEGIN:   cfg.code_begin     = value[ByteW-1:0];
        REG_CODE_END:     cfg.code_end       = value[ByteW-1:0];
        REG_CODE_PEN_S:   cfg.code_pen_short = value[ByteW-1:0];
        REG_CODE_PEN_L:   cfg.code_pen_long  = value[ByteW-1:0];
        REG_CODE_DRAW:    cfg.code_draw      = value[ByteW-1:0];
        REG_CODE_MOVE:    cfg.code_move      = value[ByteW-1:0];
        REG_CODE_SPECIAL: cfg.code_special   = value[ByteW-1:0];
        default: ;
      endcase
    endfunction

    function void queue_result(input logic [ActW-1:0] act, input logic [PenW-1:0] pen,
                               input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                               input logic [FaultW-1:0] fault);
      plot_action_t a;
      a.action = act;
      a.pen    = pen;
      a.x      = x;
      a.y      = y;
      a.fault  = fault;
      owed_actions.push_back(a);
    endfunction

    function void stop_with_fault(input logic [FaultW-1:0] fault);
      halted = 1'b1;
      queue_result(ACT_FAULT, '0, '0, '0, fault);
    endfunction

    function void select_pen();
      int unsigned pens;
      int unsigned pen;
      // a pen count of zero behaves as a single pen
      pens   = (cfg.pen_count == '0) ? 1 : int'(cfg.pen_count);
      pen    = int'(pen_acc) % pens + 1;
      pstate = AWAIT_CMD;
      queue_result(ACT_PEN, PenW'(pen), '0, '0, FLT_NONE);
    endfunction

    function void note_byte(input logic [ByteW-1:0] b, input logic eos);
      if (halted) return;
      if (pstate == AWAIT_BEGIN) begin
        if (eos || b != cfg.code_begin) begin
          stop_with_fault(FLT_NO_BEGIN);
        end else begin
          pstate = AWAIT_CMD;
          queue_result(ACT_START, '0, '0, '0, FLT_NONE);
        end
      end else if (pstate == AWAIT_CMD) begin
        if (eos) begin
          stop_with_fault(FLT_EOF_CMD);
        end else if (b == cfg.code_end) begin
          halted = 1'b1;
          queue_result(ACT_FINISH, '0, '0, '0, FLT_NONE);
        end else if (b == cfg.code_pen_long) begin
          pstate = LPEN_HI;
        end else if (b == cfg.code_pen_short) begin
          pstate = PEN_BYTE;
        end else if (b == cfg.code_draw) begin
          draw_cmd = 1'b1;
          pstate   = X_HI;
        end else if (b == cfg.code_move) begin
          draw_cmd = 1'b0;
          pstate   = X_HI;
        end else if (b == cfg.code_special) begin
          pstate = SKIP_SPECIAL;
        end else begin
          stop_with_fault(FLT_BAD_CODE);
        end
      end else if (eos) begin
        stop_with_fault(FLT_EOF_FIELD);
      end else begin
        case (pstate)
          PEN_BYTE: begin
            pen_acc = {16'd0, b};
            select_pen();
          end
          LPEN_HI: begin
            pen_acc = {16'd0, b};
            pstate  = LPEN_MID;
          end
          LPEN_MID: begin
            pen_acc = {pen_acc[15:0], b};
            pstate  = LPEN_LO;
          end
          LPEN_LO: begin
            pen_acc = {pen_acc[15:0], b};
            select_pen();
          end
          X_HI: begin
            hi_hold = b;
            pstate  = X_LO;
          end
          X_LO: begin
            x_hold = {hi_hold, b};
            pstate = Y_HI;
          end
          Y_HI: begin
            hi_hold = b;
            pstate  = Y_LO;
          end
          Y_LO: begin
            pstate = AWAIT_CMD;
            queue_result(draw_cmd ? ACT_DRAW : ACT_MOVE, '0, x_hold, {hi_hold, b}, FLT_NONE);
          end
          SKIP_SPECIAL: begin
            if (b == '0) pstate = AWAIT_CMD;
          end
          default: pstate = AWAIT_CMD;
        endcase
      end
    endfunction

    function void compare_field(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_action(input logic [47:0] data, input logic [ActW-1:0] act);
      plot_action_t want;
      if (owed_actions.size() == 0) begin
        $display("%0t: action %0d arrived with nothing outstanding, expected none, actual %0h",
                 $time, act, data);
        mismatches++;
        return;
      end
      want = owed_actions.pop_front();
      compare_field("action", 16'(want.action), 16'(act));
      compare_field("pen_number", 16'(want.pen), 16'(data[10:0]));
      compare_field("coord_x", want.x, data[26:11]);
      compare_field("coord_y", want.y, data[42:27]);
      compare_field("fault_code", 16'(want.fault), 16'(data[44:43]));
      compare_field("tdata padding", 16'd0, 16'(data[47:45]));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;   // [7:0] data_byte
  logic              s_axis_tuser;   // [0] stream_end
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // [10:0] pen_number, [26:11] coord_x, [42:27] coord_y, [44:43] fault_code
  logic [47:0]       m_axis_tdata;
  logic [2:0]        m_axis_tuser;   // [2:0] action
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  plot_stream_tracker tracker = new();
  int unsigned        beats_sent;
  bit                 tx_idle_on;
  bit                 rx_idle_on;

  plot_command_stream_parser_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) tracker.note_byte(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) tracker.check_action(m_axis_tdata, m_axis_tuser);
    end
  end

  // result side back-pressure
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL plot_command_stream_parser_top");
    $finish;
  end

  function automatic logic [ByteW-1:0] code_of(input cmd_kind_e k);
    case (k)
      CMD_PEN_LONG:  return tracker.cfg.code_pen_long;
      CMD_PEN_SHORT: return tracker.cfg.code_pen_short;
      CMD_DRAW:      return tracker.cfg.code_draw;
      CMD_MOVE:      return tracker.cfg.code_move;
      default:       return tracker.cfg.code_special;
    endcase
  endfunction

  // a command is shadowed when a code matched earlier has the same value
  function automatic bit reachable(input cmd_kind_e k);
    logic [ByteW-1:0] c;
    c = code_of(k);
    if (c == tracker.cfg.code_end) return 1'b0;
    for (int j = 0; j < int'(k); j++) begin
      if (code_of(cmd_kind_e'(j)) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit pick_kind(output cmd_kind_e k);
    int unsigned first;
    first = $urandom_range(0, 4);
    k     = CMD_PEN_LONG;
    for (int j = 0; j < 5; j++) begin
      k = cmd_kind_e'((first + j) % 5);
      if (reachable(k)) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_beat(input logic [ByteW-1:0] b, input logic eos);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic send_command(input cmd_kind_e k, input logic [31:0] arg,
                              input int unsigned skip_len);
    send_beat(code_of(k), 1'b0);
    case (k)
      CMD_PEN_SHORT: send_beat(arg[7:0], 1'b0);
      CMD_PEN_LONG: begin
        send_beat(arg[23:16], 1'b0);
        send_beat(arg[15:8], 1'b0);
        send_beat(arg[7:0], 1'b0);
      end
      CMD_DRAW, CMD_MOVE: begin
        send_beat(arg[31:24], 1'b0);
        send_beat(arg[23:16], 1'b0);
        send_beat(arg[15:8], 1'b0);
        send_beat(arg[7:0], 1'b0);
      end
      default: begin
        repeat (skip_len) send_beat(8'($urandom_range(1, 255)), 1'b0);
        send_beat(8'h00, 1'b0);
      end
    endcase
  endtask

  // stop sending until every owed action is out and the block has settled
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    tracker.write_reg(idx, value);
  endtask

  task automatic start_phase(input int unsigned phase_no);
    logic [PenW-1:0]  pens;
    logic [ByteW-1:0] codes [8];
    wait_drained();
    for (int i = 0; i < 8; i++) codes[i] = 8'($urandom_range(0, 255));
    pens = PenW'($urandom_range(1, 16));
    case (phase_no)
      1: begin
        pens  = 11'd1024;
        codes = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'hFF};
      end
      2: begin
        // short pen, move and special all shadowed by earlier matches
        pens  = '0;
        codes = '{8'h00, 8'h00, 8'hFE, 8'h10, 8'h10, 8'h20, 8'h20, 8'hFE};
      end
      3: pens = 11'd2047;
      default: begin
        if ($urandom_range(0, 2) == 0) pens = PenW'($urandom_range(17, 1024));
        if ($urandom_range(0, 2) == 0) codes[$urandom_range(2, 7)] = codes[$urandom_range(2, 7)];
      end
    endcase
    write_reg(REG_PEN_COUNT, 32'(pens));
    for (int i = 1; i < 8; i++) write_reg(RegIdxW'(i), 32'(codes[i]));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tx_idle_on = beats_sent < 1100 && $urandom_range(0, 3) != 0;
    rx_idle_on = beats_sent < 1100 && $urandom_range(0, 3) != 0;
  endtask

  task automatic random_command(output bit ok);
    cmd_kind_e k;
    ok = pick_kind(k);
    if (!ok) return;
    send_command(k, $urandom, $urandom_range(0, 5));
    if ($urandom_range(0, 49) == 0) wait_drained();
  endtask

  task automatic end_plot();
    cmd_kind_e        k;
    logic [ByteW-1:0] b;
    int unsigned      how;
    k   = CMD_PEN_LONG;
    how = $urandom_range(0, 3);
    if (how == 2) begin
      if (!pick_kind(k)) how = 1;
    end
    case (how)
      0: send_beat(tracker.cfg.code_end, 1'b0);
      1: send_beat(8'($urandom), 1'b1);
      2: begin
        // stream ends partway through a command's bytes
        send_beat(code_of(k), 1'b0);
        case (k)
          CMD_PEN_SHORT: how = 0;
          CMD_PEN_LONG:  how = $urandom_range(0, 2);
          CMD_SPECIAL:   how = $urandom_range(0, 4);
          default:       how = $urandom_range(0, 3);
        endcase
        repeat (how) send_beat(8'($urandom_range(1, 255)), 1'b0);
        send_beat(8'($urandom), 1'b1);
      end
      default: begin
        b = 8'($urandom);
        while (b == tracker.cfg.code_end || b == tracker.cfg.code_pen_long ||
               b == tracker.cfg.code_pen_short || b == tracker.cfg.code_draw ||
               b == tracker.cfg.code_move || b == tracker.cfg.code_special) b++;
        send_beat(b, 1'b0);
      end
    endcase
    // halted now, these beats must be dropped
    repeat (8) send_beat(8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned quota;
    bit          ok;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    beats_sent = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // command codes keep their reset values for the first stretch
    write_reg(REG_CODE_BEGIN, 32'($urandom_range(0, 255)));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;

    send_beat(tracker.cfg.code_begin, 1'b0);
    send_command(CMD_PEN_SHORT, 32'h00, 0);
    send_command(CMD_PEN_SHORT, 32'hFF, 0);
    send_command(CMD_PEN_LONG, 32'h000000, 0);
    send_command(CMD_PEN_LONG, 32'hFFFFFF, 0);
    send_command(CMD_MOVE, 32'h0000_0000, 0);
    send_command(CMD_DRAW, 32'hFFFF_FFFF, 0);
    send_command(CMD_SPECIAL, 32'h0, 0);
    // special body full of bytes that look like commands
    send_beat(tracker.cfg.code_special, 1'b0);
    send_beat(tracker.cfg.code_end, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);

    ok = 1'b1;
    while (ok && beats_sent < PHASE_BEATS) random_command(ok);

    phase_no = 1;
    while (beats_sent < ITEM_TARGET) begin
      start_phase(phase_no);
      phase_no++;
      quota = beats_sent + PHASE_BEATS;
      ok    = 1'b1;
      while (ok && beats_sent < quota && beats_sent < ITEM_TARGET) random_command(ok);
    end

    end_plot();
    wait_drained();

    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("PASS plot_command_stream_parser_top");
    end else begin
      $display("FAIL plot_command_stream_parser_top");
    end
    $finish;
  end

endmodule
